// ===== rtl/mfq_pkg.sv =====
// shared types, constants and codes of the multilevel feedback queue scheduler
`timescale 1ns / 1ps
`default_nettype none
package mfq_pkg;

   // default sizes
   localparam int THREADS_DEF = 64;
   localparam int LEVELS_DEF  = 4;

   // field widths
   localparam int TID_W      = 6;
   localparam int OP_W       = 2;
   localparam int EV_W       = 2;
   localparam int RT_W       = 16;
   localparam int TQ_W       = 16;
   localparam int BP_W       = 8;
   localparam int ACC_W      = 32;
   localparam int THR_W      = TQ_W + BP_W;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // register reset values
   localparam logic [TQ_W-1:0] TQ_RESET = TQ_W'(10);
   localparam logic [BP_W-1:0] BP_RESET = BP_W'(8);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_QUANTUM = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOST_PERIOD = 1'b1;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_ADMIT    = 2'd0,
      OP_WAKE     = 2'd1,
      OP_SCHEDULE = 2'd2
   } op_type;

   // schedule reasons
   typedef enum logic [EV_W-1:0] {
      EV_TIMER   = 2'd0,
      EV_YIELD   = 2'd1,
      EV_BLOCKED = 2'd2,
      EV_EXITED  = 2'd3
   } event_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADMIT,
      ST_CHECK,
      ST_BST_START,
      ST_BST_WALK,
      ST_BST_NEXT,
      ST_BST_SPLICE,
      ST_DECIDE,
      ST_REQUEUE,
      ST_PICK,
      ST_PICK_LINK,
      ST_FINISH
   } state_type;

   // datapath commands
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_CAPTURE,
      CMD_ADMIT,
      CMD_CHECK,
      CMD_BST_START,
      CMD_BST_WALK,
      CMD_BST_NEXT,
      CMD_BST_SPLICE,
      CMD_DECIDE,
      CMD_REQUEUE,
      CMD_PICK,
      CMD_PICK_LINK,
      CMD_FINISH
   } cmd_type;

   // datapath status seen by the controller
   typedef struct packed {
      logic boost_hit;
      logic multi_level;
      logic lvl_nonempty;
      logic last_level;
      logic walk_last;
      logic running;
      logic keep;
      logic requeue_event;
      logic any_nonempty;
      logic pick_last;
      logic rsp_free;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/mfq_datapath.sv =====
// datapath: queues, thread memories, accumulator, configuration and result register
`timescale 1ns / 1ps
`default_nettype none
module mfq_datapath import mfq_pkg::*; #(
   parameter int THREADS = THREADS_DEF,
   parameter int LEVELS  = LEVELS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic [OP_W-1:0]       req_operation,
   input  wire logic [TID_W-1:0]      req_thread_id,
   input  wire logic [EV_W-1:0]       req_event_kind,
   input  wire logic [RT_W-1:0]       req_run_time,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [TID_W-1:0]           rsp_run_thread,
   output logic                       rsp_idle,
   output logic                       rsp_kept,
   output logic                       rsp_boosted
);

   localparam int TW = $clog2(THREADS);
   localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   // configuration
   logic [TQ_W-1:0]  tq_ff;
   logic [BP_W-1:0]  bp_ff;
   logic [THR_W-1:0] thr_ff;
   logic [TQ_W-1:0]  q_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tq_ff <= TQ_RESET;
         bp_ff <= BP_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TIME_QUANTUM: tq_ff <= csr_write_data[TQ_W-1:0];
            CSR_BOOST_PERIOD: bp_ff <= csr_write_data[BP_W-1:0];
            default: ;
         endcase
      end
   end

   // boost threshold, period times quantum
   assign q_eff = (tq_ff == '0) ? TQ_W'(1) : tq_ff;
   always_ff @(posedge clock) begin
      thr_ff <= THR_W'(bp_ff) * THR_W'(q_eff);
   end

   // state registers
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic [TID_W-1:0] tid_ff, tid_in;
   logic [EV_W-1:0]  ev_ff, ev_in;
   logic [RT_W-1:0]  rt_ff, rt_in;
   logic             kept_ff, kept_in;
   logic             boosted_ff, boosted_in;
   logic             requeue_ff, requeue_in;
   logic [TW-1:0]    run_ff, run_in;
   logic             rv_ff, rv_in;
   logic [TW-1:0]    walk_ff, walk_in;
   logic [LW-1:0]    ctr_ff, ctr_in;
   logic [LW-1:0]    pick_ff, pick_in;
   logic [TW-1:0]    head_ff [LEVELS];
   logic [TW-1:0]    head_in [LEVELS];
   logic [TW-1:0]    tail_ff [LEVELS];
   logic [TW-1:0]    tail_in [LEVELS];
   logic [LEVELS-1:0]  ne_ff, ne_in;
   logic [THREADS-1:0] queued_ff, queued_in;
   logic [THREADS-1:0] lvl_vld_ff, lvl_vld_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [TID_W-1:0] rsp_thread_ff, rsp_thread_in;
   logic             rsp_idle_ff, rsp_idle_in;
   logic             rsp_kept_ff, rsp_kept_in;
   logic             rsp_boosted_ff, rsp_boosted_in;

   // thread memories
   logic [LW-1:0] level_mem [THREADS];
   logic [TW-1:0] link_mem [THREADS];
   logic [LW-1:0] lvl_q;
   logic          lvl_vq;
   logic [TW-1:0] link_q;
   logic [TW-1:0] lvl_rd_addr, link_rd_addr;
   logic          lw_en, kw_en;
   logic [TW-1:0] lw_addr, kw_addr;
   logic [LW-1:0] lw_data;
   logic [TW-1:0] kw_data;

   // helpers
   logic [TW-1:0]    tid_idx;
   logic             tid_ok;
   logic             admit_ok;
   logic [LW-1:0]    level_cur;
   logic [LW-1:0]    level_new;
   logic             keep;
   logic             any_ne;
   logic [LW-1:0]    pick_lvl;
   logic [TW-1:0]    pick_t;
   logic [ACC_W:0]   sum_wide;
   logic [ACC_W-1:0] acc_sat;
   logic             rsp_free;
   logic             push_en;
   logic [LW-1:0]    push_lvl;
   logic [TW-1:0]    push_t;

   assign tid_idx   = TW'(tid_ff);
   assign tid_ok    = 32'(tid_ff) < THREADS;
   assign admit_ok  = tid_ok && !queued_ff[tid_idx] && !(rv_ff && run_ff == tid_idx);
   assign level_cur = lvl_vq ? lvl_q : '0;
   assign level_new = ((rt_ff >= tq_ff) && (32'(level_cur) + 1 < LEVELS)) ?
                      LW'(level_cur + LW'(1)) : level_cur;
   assign keep      = (ev_ff == EV_TIMER) && (rt_ff < tq_ff);
   assign any_ne    = |ne_ff;
   assign sum_wide  = {1'b0, acc_ff} + (ACC_W+1)'(rt_ff);
   assign acc_sat   = sum_wide[ACC_W] ? '1 : sum_wide[ACC_W-1:0];
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // highest non-empty level
   always_comb begin
      pick_lvl = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (ne_ff[i]) pick_lvl = LW'(i);
      end
   end
   assign pick_t = head_ff[pick_lvl];

   // memory read addresses
   assign lvl_rd_addr  = (cmd == CMD_CAPTURE) ? TW'(req_thread_id) : run_ff;
   assign link_rd_addr = (cmd == CMD_PICK) ? pick_t : walk_ff;

   // registered memory reads
   always_ff @(posedge clock) begin
      lvl_q  <= level_mem[lvl_rd_addr];
      lvl_vq <= lvl_vld_ff[lvl_rd_addr];
      link_q <= link_mem[link_rd_addr];
   end

   // memory writes
   always_ff @(posedge clock) begin
      if (lw_en) level_mem[lw_addr] <= lw_data;
      if (kw_en) link_mem[kw_addr] <= kw_data;
   end

   // next state
   always_comb begin
      acc_in         = acc_ff;
      op_in          = op_ff;
      tid_in         = tid_ff;
      ev_in          = ev_ff;
      rt_in          = rt_ff;
      kept_in        = kept_ff;
      boosted_in     = boosted_ff;
      requeue_in     = requeue_ff;
      run_in         = run_ff;
      rv_in          = rv_ff;
      walk_in        = walk_ff;
      ctr_in         = ctr_ff;
      pick_in        = pick_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      ne_in          = ne_ff;
      queued_in      = queued_ff;
      lvl_vld_in     = lvl_vld_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_thread_in  = rsp_thread_ff;
      rsp_idle_in    = rsp_idle_ff;
      rsp_kept_in    = rsp_kept_ff;
      rsp_boosted_in = rsp_boosted_ff;
      lw_en    = 1'b0;
      lw_addr  = run_ff;
      lw_data  = '0;
      kw_en    = 1'b0;
      kw_addr  = tail_ff[0];
      kw_data  = '0;
      push_en  = 1'b0;
      push_lvl = '0;
      push_t   = run_ff;

      case (cmd)
         CMD_CAPTURE: begin
            op_in      = req_operation;
            tid_in     = req_thread_id;
            ev_in      = req_event_kind;
            rt_in      = req_run_time;
            kept_in    = 1'b0;
            boosted_in = 1'b0;
            requeue_in = 1'b0;
         end
         CMD_ADMIT: begin
            if (admit_ok) begin
               push_en  = 1'b1;
               push_t   = tid_idx;
               push_lvl = (op_ff == OP_ADMIT) ? '0 : level_cur;
               if (op_ff == OP_ADMIT) begin
                  lw_en   = 1'b1;
                  lw_addr = tid_idx;
                  lw_data = '0;
               end
            end
         end
         CMD_CHECK: begin
            if (acc_ff >= ACC_W'(thr_ff)) begin
               acc_in     = '0;
               boosted_in = 1'b1;
               ctr_in     = LW'(1);
            end
         end
         CMD_BST_START: begin
            if (ne_ff[ctr_ff]) walk_in = head_ff[ctr_ff];
            else ctr_in = LW'(ctr_ff + LW'(1));
         end
         CMD_BST_WALK: begin
            lw_en   = 1'b1;
            lw_addr = walk_ff;
            lw_data = '0;
         end
         CMD_BST_NEXT: begin
            walk_in = link_q;
         end
         CMD_BST_SPLICE: begin
            // append the whole list of this level behind the top level
            if (ne_ff[0]) begin
               kw_en   = 1'b1;
               kw_addr = tail_ff[0];
               kw_data = head_ff[ctr_ff];
            end else begin
               head_in[0] = head_ff[ctr_ff];
               ne_in[0]   = 1'b1;
            end
            tail_in[0]     = tail_ff[ctr_ff];
            ne_in[ctr_ff]  = 1'b0;
            ctr_in         = LW'(ctr_ff + LW'(1));
         end
         CMD_DECIDE: begin
            if (rv_ff) begin
               if (keep) kept_in = 1'b1;
               else if (ev_ff == EV_BLOCKED || ev_ff == EV_EXITED) acc_in = acc_sat;
            end
         end
         CMD_REQUEUE: begin
            lw_en      = 1'b1;
            lw_addr    = run_ff;
            lw_data    = level_new;
            push_en    = 1'b1;
            push_t     = run_ff;
            push_lvl   = level_new;
            requeue_in = 1'b1;
         end
         CMD_PICK: begin
            if (any_ne) begin
               queued_in[pick_t] = 1'b0;
               run_in  = pick_t;
               rv_in   = 1'b1;
               pick_in = pick_lvl;
               if (pick_t == tail_ff[pick_lvl]) ne_in[pick_lvl] = 1'b0;
               if (requeue_ff && pick_t != run_ff) acc_in = acc_sat;
            end else begin
               rv_in  = 1'b0;
               run_in = '0;
            end
         end
         CMD_PICK_LINK: begin
            head_in[pick_ff] = link_q;
         end
         CMD_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_thread_in  = rv_ff ? TID_W'(run_ff) : '0;
               rsp_idle_in    = !rv_ff;
               rsp_kept_in    = kept_ff;
               rsp_boosted_in = boosted_ff;
            end
         end
         default: ;
      endcase

      // append one thread to a level
      if (push_en) begin
         if (ne_ff[push_lvl]) begin
            kw_en   = 1'b1;
            kw_addr = tail_ff[push_lvl];
            kw_data = push_t;
         end else begin
            head_in[push_lvl] = push_t;
            ne_in[push_lvl]   = 1'b1;
         end
         tail_in[push_lvl] = push_t;
         queued_in[push_t] = 1'b1;
      end

      if (lw_en) lvl_vld_in[lw_addr] = 1'b1;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         run_ff       <= '0;
         rv_ff        <= 1'b0;
         ne_ff        <= '0;
         queued_ff    <= '0;
         lvl_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         run_ff       <= run_in;
         rv_ff        <= rv_in;
         ne_ff        <= ne_in;
         queued_ff    <= queued_in;
         lvl_vld_ff   <= lvl_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      tid_ff         <= tid_in;
      ev_ff          <= ev_in;
      rt_ff          <= rt_in;
      kept_ff        <= kept_in;
      boosted_ff     <= boosted_in;
      requeue_ff     <= requeue_in;
      walk_ff        <= walk_in;
      ctr_ff         <= ctr_in;
      pick_ff        <= pick_in;
      head_ff        <= head_in;
      tail_ff        <= tail_in;
      rsp_thread_ff  <= rsp_thread_in;
      rsp_idle_ff    <= rsp_idle_in;
      rsp_kept_ff    <= rsp_kept_in;
      rsp_boosted_ff <= rsp_boosted_in;
   end

   // status to the controller
   always_comb begin
      status.boost_hit     = acc_ff >= ACC_W'(thr_ff);
      status.multi_level   = LEVELS > 1;
      status.lvl_nonempty  = ne_ff[ctr_ff];
      status.last_level    = 32'(ctr_ff) == LEVELS - 1;
      status.walk_last     = walk_ff == tail_ff[ctr_ff];
      status.running       = rv_ff;
      status.keep          = keep;
      status.requeue_event = (ev_ff == EV_TIMER) || (ev_ff == EV_YIELD);
      status.any_nonempty  = any_ne;
      status.pick_last     = pick_t == tail_ff[pick_lvl];
      status.rsp_free      = rsp_free;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_run_thread = rsp_thread_ff;
   assign rsp_idle       = rsp_idle_ff;
   assign rsp_kept       = rsp_kept_ff;
   assign rsp_boosted    = rsp_boosted_ff;

endmodule
`default_nettype wire

// ===== rtl/mfq_controller.sv =====
// controller state machine that sequences admit, wake, boost and dispatch steps
`timescale 1ns / 1ps
`default_nettype none
module mfq_controller import mfq_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic [OP_W-1:0] req_operation,
   output logic                 req_stall,
   output cmd_type              cmd,
   input  wire status_type      status
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = CMD_NONE;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd = CMD_CAPTURE;
               case (req_operation)
                  OP_ADMIT, OP_WAKE: state_in = ST_ADMIT;
                  OP_SCHEDULE:       state_in = ST_CHECK;
                  default:           state_in = ST_FINISH;
               endcase
            end
         end
         ST_ADMIT: begin
            cmd      = CMD_ADMIT;
            state_in = ST_FINISH;
         end
         ST_CHECK: begin
            cmd = CMD_CHECK;
            if (status.boost_hit && status.multi_level) state_in = ST_BST_START;
            else state_in = ST_DECIDE;
         end
         ST_BST_START: begin
            cmd = CMD_BST_START;
            if (status.lvl_nonempty) state_in = ST_BST_WALK;
            else if (status.last_level) state_in = ST_DECIDE;
         end
         ST_BST_WALK: begin
            cmd = CMD_BST_WALK;
            state_in = status.walk_last ? ST_BST_SPLICE : ST_BST_NEXT;
         end
         ST_BST_NEXT: begin
            cmd      = CMD_BST_NEXT;
            state_in = ST_BST_WALK;
         end
         ST_BST_SPLICE: begin
            cmd = CMD_BST_SPLICE;
            state_in = status.last_level ? ST_DECIDE : ST_BST_START;
         end
         ST_DECIDE: begin
            cmd = CMD_DECIDE;
            if (!status.running) state_in = ST_PICK;
            else if (status.keep) state_in = ST_FINISH;
            else if (status.requeue_event) state_in = ST_REQUEUE;
            else state_in = ST_PICK;
         end
         ST_REQUEUE: begin
            cmd      = CMD_REQUEUE;
            state_in = ST_PICK;
         end
         ST_PICK: begin
            cmd = CMD_PICK;
            if (!status.any_nonempty || status.pick_last) state_in = ST_FINISH;
            else state_in = ST_PICK_LINK;
         end
         ST_PICK_LINK: begin
            cmd      = CMD_PICK_LINK;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd = CMD_FINISH;
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/multilevel_feedback_queue_scheduler.sv =====
// top level of the multilevel feedback queue scheduler
`timescale 1ns / 1ps
`default_nettype none
// Thread scheduler with LEVELS priority FIFOs linked through a per-thread link
// memory. One transaction is taken at a time. A schedule transaction takes
// longer for each thread moved and each lower level visited when a priority
// boost walks the lower queues to reset their levels. The sequencer works with
// registered reads of the level and link memories. A finished result sits in an
// output register, and the next transaction is accepted as soon as the
// sequencer is back in idle.
module multilevel_feedback_queue_scheduler import mfq_pkg::*; #(
   parameter int THREADS = THREADS_DEF,
   parameter int LEVELS  = LEVELS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [OP_W-1:0]       req_operation,
   input  wire logic [TID_W-1:0]      req_thread_id,
   input  wire logic [EV_W-1:0]       req_event_kind,
   input  wire logic [RT_W-1:0]       req_run_time,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [TID_W-1:0]           rsp_run_thread,
   output logic                       rsp_idle,
   output logic                       rsp_kept,
   output logic                       rsp_boosted,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   mfq_controller u_controller (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .cmd           (cmd),
      .status        (status)
   );

   // queues, memories and result register
   mfq_datapath #(
      .THREADS (THREADS),
      .LEVELS  (LEVELS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_thread_id    (req_thread_id),
      .req_event_kind   (req_event_kind),
      .req_run_time     (req_run_time),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_run_thread   (rsp_run_thread),
      .rsp_idle         (rsp_idle),
      .rsp_kept         (rsp_kept),
      .rsp_boosted      (rsp_boosted)
   );

endmodule
`default_nettype wire

// ===== bench/mfq_checker.sv =====
// checker for the multilevel feedback queue scheduler: predicts and compares results
`timescale 1ns / 1ps
`default_nettype none
module mfq_checker import mfq_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic [OP_W-1:0]       req_operation,
   input  wire logic [TID_W-1:0]      req_thread_id,
   input  wire logic [EV_W-1:0]       req_event_kind,
   input  wire logic [RT_W-1:0]       req_run_time,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic [TID_W-1:0]      rsp_run_thread,
   input  wire logic                  rsp_idle,
   input  wire logic                  rsp_kept,
   input  wire logic                  rsp_boosted,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   output int                         fail_count,
   output int                         pending,
   output int                         boost_count,
   output int                         kept_count
);

   localparam int NTHR = THREADS_DEF;
   localparam int NLVL = LEVELS_DEF;

   typedef struct packed {
      logic [TID_W-1:0] run_thread;
      logic             idle;
      logic             kept;
      logic             boosted;
   } decision_type;

   // shadow scheduler state
   logic [1:0]       lvl_of [NTHR];
   logic             is_queued [NTHR];
   logic [TID_W-1:0] link [NTHR];
   logic [TID_W-1:0] head [NLVL];
   logic [TID_W-1:0] tail [NLVL];
   logic             busy_lvl [NLVL];
   logic [TID_W-1:0] cur_thread;
   logic             cur_valid;
   logic [ACC_W-1:0] run_sum;
   logic [TQ_W-1:0]  quantum;
   logic [BP_W-1:0]  period;

   decision_type decisions_due[$];

   function automatic void enqueue(int lv, logic [TID_W-1:0] t);
      if (busy_lvl[lv]) begin
         link[tail[lv]] = t;
         tail[lv] = t;
      end else begin
         head[lv] = t;
         tail[lv] = t;
         busy_lvl[lv] = 1'b1;
      end
      is_queued[t] = 1'b1;
   endfunction

   function automatic logic [TID_W-1:0] dequeue(int lv);
      logic [TID_W-1:0] t;
      t = head[lv];
      if (t == tail[lv]) busy_lvl[lv] = 1'b0;
      else head[lv] = link[t];
      is_queued[t] = 1'b0;
      return t;
   endfunction

   function automatic logic pick_highest(output logic [TID_W-1:0] t);
      t = '0;
      for (int lv = 0; lv < NLVL; lv++) begin
         if (busy_lvl[lv]) begin
            t = dequeue(lv);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void add_runtime(logic [RT_W-1:0] rt);
      logic [ACC_W:0] s;
      s = {1'b0, run_sum} + rt;
      run_sum = s[ACC_W] ? '1 : s[ACC_W-1:0];
   endfunction

   // scheduling decision for one transaction
   function automatic decision_type schedule_step(op_type op, logic [TID_W-1:0] tid,
                                                  event_type ev, logic [RT_W-1:0] rt);
      decision_type d;
      logic [TID_W-1:0] nxt, prev;
      logic [ACC_W-1:0] limit_sum;
      logic [TQ_W-1:0] q;
      d = '0;
      nxt = '0;
      if (op == OP_ADMIT || op == OP_WAKE) begin
         if (!is_queued[tid] && !(cur_valid && cur_thread == tid)) begin
            if (op == OP_ADMIT) lvl_of[tid] = 2'd0;
            enqueue(lvl_of[tid], tid);
         end
      end else if (op == OP_SCHEDULE) begin
         q = (quantum == 0) ? TQ_W'(1) : quantum;
         limit_sum = ACC_W'(period) * ACC_W'(q);
         // priority boost
         if (run_sum >= limit_sum) begin
            run_sum = '0;
            d.boosted = 1'b1;
            for (int lv = 1; lv < NLVL; lv++) begin
               while (busy_lvl[lv]) begin
                  nxt = dequeue(lv);
                  lvl_of[nxt] = 2'd0;
                  enqueue(0, nxt);
               end
            end
         end
         if (!cur_valid) begin
            cur_valid = pick_highest(nxt);
            cur_thread = cur_valid ? nxt : '0;
         end else if (ev == EV_TIMER && rt < quantum) begin
            d.kept = 1'b1;
         end else if (ev == EV_TIMER || ev == EV_YIELD) begin
            prev = cur_thread;
            if (rt >= quantum && lvl_of[prev] != 2'(NLVL - 1)) lvl_of[prev]++;
            enqueue(lvl_of[prev], prev);
            void'(pick_highest(nxt));
            if (nxt != prev) add_runtime(rt);
            cur_thread = nxt;
         end else begin
            add_runtime(rt);
            cur_valid = pick_highest(nxt);
            cur_thread = cur_valid ? nxt : '0;
         end
      end
      d.run_thread = cur_valid ? cur_thread : '0;
      d.idle = !cur_valid;
      return d;
   endfunction

   task automatic report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   // watch the channels
   always @(posedge clock) begin
      decision_type want;
      if (reset) begin
         for (int i = 0; i < NTHR; i++) begin
            lvl_of[i] = '0;
            is_queued[i] = 1'b0;
         end
         for (int i = 0; i < NLVL; i++) busy_lvl[i] = 1'b0;
         cur_thread = '0;
         cur_valid = 1'b0;
         run_sum = '0;
         quantum = TQ_RESET;
         period = BP_RESET;
         decisions_due.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_TIME_QUANTUM) quantum = csr_write_data[TQ_W-1:0];
            else if (csr_index == CSR_BOOST_PERIOD) period = csr_write_data[BP_W-1:0];
         end
         // compare a result transaction with the oldest decision
         if (rsp_valid && !rsp_stall) begin
            if (decisions_due.size() == 0) begin
               report("result with no transaction outstanding");
            end else begin
               want = decisions_due.pop_front();
               if (rsp_boosted) boost_count++;
               if (rsp_kept) kept_count++;
               if (rsp_run_thread !== want.run_thread)
                  report($sformatf("run_thread %0d, want %0d", rsp_run_thread,
                                   want.run_thread));
               if (rsp_idle !== want.idle)
                  report($sformatf("idle %b, want %b", rsp_idle, want.idle));
               if (rsp_kept !== want.kept)
                  report($sformatf("kept %b, want %b", rsp_kept, want.kept));
               if (rsp_boosted !== want.boosted)
                  report($sformatf("boosted %b, want %b", rsp_boosted, want.boosted));
            end
         end
         // predict for an accepted request transaction
         if (req_valid && !req_stall)
            decisions_due.push_back(schedule_step(op_type'(req_operation), req_thread_id,
                                                  event_type'(req_event_kind),
                                                  req_run_time));
      end
      pending = decisions_due.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
      boost_count = 0;
      kept_count = 0;
   end

endmodule
`default_nettype wire

// ===== bench/tb_multilevel_feedback_queue_scheduler.sv =====
// testbench top of the multilevel feedback queue scheduler: stimulus and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_multilevel_feedback_queue_scheduler;
   import mfq_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int RANDOM_ITEMS = 350;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [OP_W-1:0]       req_operation = OP_ADMIT;
   logic [TID_W-1:0]      req_thread_id = '0;
   logic [EV_W-1:0]       req_event_kind = EV_TIMER;
   logic [RT_W-1:0]       req_run_time = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [TID_W-1:0]      rsp_run_thread;
   logic                  rsp_idle;
   logic                  rsp_kept;
   logic                  rsp_boosted;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_TIME_QUANTUM;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   int fail_count, pending, boost_count, kept_count;
   int cycles = 0;
   int items_sent = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   logic req_taken = 1'b0;
   logic [TQ_W-1:0] cur_quantum = TQ_RESET;

   multilevel_feedback_queue_scheduler DUT (.*);

   mfq_checker u_checker (.*);

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // handshake sample and run limit
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("multilevel_feedback_queue_scheduler verification failed");
         $finish;
      end
   end

   // receiver stall
   always @(negedge clock)
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);

   // one request transaction, then an optional gap
   task automatic send(op_type op, logic [TID_W-1:0] tid, event_type ev,
                       logic [RT_W-1:0] rt);
      req_valid = 1'b1;
      req_operation = op;
      req_thread_id = tid;
      req_event_kind = ev;
      req_run_time = rt;
      @(negedge clock);
      while (!req_taken) @(negedge clock);
      items_sent++;
      if ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(6, 1)) @(negedge clock);
      end
   endtask

   task automatic drain(int extra);
      req_valid = 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = val;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // random transaction weighted toward real scheduling traffic
   task automatic random_item();
      int pick;
      logic [TID_W-1:0] tid;
      logic [RT_W-1:0] rt;
      pick = $urandom_range(99);
      tid = ($urandom_range(3) == 0) ? TID_W'($urandom) : TID_W'($urandom_range(11));
      case ($urandom_range(5))
         0: rt = RT_W'($urandom);
         1: rt = cur_quantum;
         2: rt = (cur_quantum == 0) ? '0 : cur_quantum - 1'b1;
         3: rt = RT_W'($urandom_range(0, cur_quantum));
         4: rt = ($urandom_range(1)) ? '1 : '0;
         default: rt = RT_W'($urandom_range(2 * cur_quantum + 1, cur_quantum));
      endcase
      if (pick < 25) send(OP_ADMIT, tid, EV_TIMER, RT_W'($urandom));
      else if (pick < 40) send(OP_WAKE, tid, event_type'($urandom_range(3)), rt);
      else send(OP_SCHEDULE, TID_W'($urandom), event_type'($urandom_range(3)), rt);
   endtask

   task automatic set_regs(logic [TQ_W-1:0] tq, logic [BP_W-1:0] bp);
      write_reg(CSR_TIME_QUANTUM, tq);
      write_reg(CSR_BOOST_PERIOD, CSR_DATA_W'(bp));
      cur_quantum = tq;
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: corner cases under reset settings
      send(OP_SCHEDULE, '0, EV_TIMER, '1);
      send(OP_ADMIT, 6'd0, EV_TIMER, '0);
      send(OP_ADMIT, 6'd63, EV_EXITED, '1);
      send(OP_ADMIT, 6'd0, EV_TIMER, '0);
      send(OP_WAKE, 6'd63, EV_TIMER, '0);
      send(OP_SCHEDULE, '1, EV_YIELD, '1);
      send(OP_ADMIT, 6'd0, EV_TIMER, '0);
      send(OP_SCHEDULE, '0, EV_TIMER, '0);
      send(OP_SCHEDULE, '0, EV_TIMER, 16'd9);
      send(OP_SCHEDULE, '0, EV_TIMER, 16'd10);
      send(OP_SCHEDULE, '0, EV_YIELD, 16'd3);
      send(OP_SCHEDULE, '0, EV_YIELD, '1);
      send(OP_SCHEDULE, '0, EV_BLOCKED, 16'd40);
      send(OP_WAKE, 6'd0, EV_TIMER, '0);
      send(OP_WAKE, 6'd5, EV_TIMER, '0);
      send(OP_SCHEDULE, '0, EV_EXITED, '1);
      send(OP_SCHEDULE, '0, EV_TIMER, '1);
      send(OP_SCHEDULE, '0, EV_EXITED, 16'd1);
      send(OP_SCHEDULE, '0, EV_BLOCKED, '0);
      send(OP_SCHEDULE, '0, EV_EXITED, '0);
      send(OP_SCHEDULE, '0, EV_YIELD, '0);
      send(OP_ADMIT, 6'd42, EV_TIMER, '0);
      send(OP_SCHEDULE, '0, EV_BLOCKED, '1);

      // pause until every result is back
      drain(8);

      // random phases with different settings and idling
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin set_regs(16'd1, 8'd0); idle_pct = 0; stall_pct = 0; end
            1: begin set_regs(16'hffff, 8'hff); idle_pct = 75; stall_pct = 0; end
            2: begin set_regs(16'd50, 8'd3); idle_pct = 0; stall_pct = 75; end
            default: begin set_regs(16'd20, 8'd2); idle_pct = 11; stall_pct = 11; end
         endcase
         repeat (RANDOM_ITEMS) random_item();
         drain(8);
      end

      drain(200);
      $display("sent %0d transactions over four register settings and idling mixes",
               items_sent);
      $display("saw %0d boosts and %0d kept decisions", boost_count, kept_count);
      if (fail_count == 0 && pending == 0)
         $display("multilevel_feedback_queue_scheduler verification clean");
      else
         $display("multilevel_feedback_queue_scheduler verification failed");
      $finish;
   end

endmodule
`default_nettype wire
